>>> design/fce_pkg.sv
// Package: shared constants, codes and types of the FIR convolution engine.
package fce_pkg;

	// Default number of cells in the tap ring
	localparam int MAX_TAPS_DEF = 64;

	// Fixed field widths
	localparam int SAMPLE_W    = 16;
	localparam int PROD_W      = 2 * SAMPLE_W;
	localparam int ACC_W       = 38;
	localparam int TAP_INDEX_W = 6;
	localparam int TAP_COUNT_W = 7;

	// Reset value of the tap count register
	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd64;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PUSH = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} fce_state_t;

	// Per-cycle control of every cell in the ring
	typedef struct packed {
		logic push;
		logic rotate;
	} cell_ctl_t;

	// Control of the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic step;
		logic active;
	} mac_ctl_t;

endpackage

>>> design/fce_in_if.sv
// Interface: input item channel (load tap or push sample).
interface fce_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  cmd;
	logic [fce_pkg::TAP_INDEX_W-1:0]       tap_index;
	logic signed [fce_pkg::SAMPLE_W-1:0]   sample_value;

	modport source (output valid, cmd, tap_index, sample_value, input ready);
	modport sink   (input valid, cmd, tap_index, sample_value, output ready);
endinterface

>>> design/fce_out_if.sv
// Interface: result channel carrying the Q30 convolution sum.
interface fce_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [fce_pkg::ACC_W-1:0]    filtered_value;

	modport source (output valid, filtered_value, input ready);
	modport sink   (input valid, filtered_value, output ready);
endinterface

>>> design/fce_cell.sv
// Ring cell: holds one delay-line sample and one tap coefficient.
module fce_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fce_pkg::cell_ctl_t                  ctl,
	input  logic                                tap_we,
	input  logic signed [fce_pkg::SAMPLE_W-1:0] tap_wdata,
	input  logic signed [fce_pkg::SAMPLE_W-1:0] sample_prev,
	input  logic signed [fce_pkg::SAMPLE_W-1:0] sample_next,
	input  logic signed [fce_pkg::SAMPLE_W-1:0] tap_next,
	output logic signed [fce_pkg::SAMPLE_W-1:0] sample_q,
	output logic signed [fce_pkg::SAMPLE_W-1:0] tap_q
);

	// Sample: shift toward older on push, rotate toward cell 0 during a pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (ctl.push) begin
			sample_q <= sample_prev;
		end else if (ctl.rotate) begin
			sample_q <= sample_next;
		end
	end

	// Tap: written by a load beat, rotates along with the sample
	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_q <= tap_wdata;
		end else if (ctl.rotate) begin
			tap_q <= tap_next;
		end
	end

endmodule

>>> design/fce_mac.sv
// Shared multiply-accumulate at the head of the ring.
module fce_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fce_pkg::mac_ctl_t                   ctl,
	input  logic signed [fce_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [fce_pkg::SAMPLE_W-1:0] tap,
	output logic signed [fce_pkg::ACC_W-1:0]    total
);

	logic signed [fce_pkg::PROD_W-1:0] prod_s1;
	logic                              pv_s1;
	logic signed [fce_pkg::ACC_W-1:0]  acc_q;
	logic signed [fce_pkg::ACC_W-1:0]  addend;

	// Product register
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			prod_s1 <= sample * tap;
		end
	end

	// Product valid: only taps inside the active count contribute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else if (ctl.clear) begin
			pv_s1 <= 1'b0;
		end else if (ctl.step) begin
			pv_s1 <= ctl.active;
		end
	end

	// Sign-extended product, zero when inactive
	assign addend = pv_s1
		? {{(fce_pkg::ACC_W-fce_pkg::PROD_W){prod_s1[fce_pkg::PROD_W-1]}}, prod_s1}
		: '0;

	// Accumulator; wraps in 38 bits
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= acc_q + addend;
		end
	end

	assign total = acc_q + addend;

endmodule

>>> design/fir_convolution_engine.sv
// Top level: FIR convolution engine built from a ring of tap cells and one MAC.
//
// Load beats (cmd = load) write one coefficient into cell tap_index; a load to
// a position at or beyond MAX_TAPS is dropped. A push beat shifts the sample
// into the delay ring and starts a pass in which every cell hands its sample and
// tap to its neighbor once per cycle, so the pair at cell 0 feeds the single
// 16x16 multiply-accumulate. A pass always walks the whole ring so the cells end
// where they began, and the block stays busy until the result is loaded into the
// output register. Only the first tap_count taps (capped at MAX_TAPS) contribute.
// The result is the exact Q30 sum, 38 bits. The delay ring resets to zero;
// taps hold no value until loaded. New beats are taken only while no pass is
// running; a finished result waits in the output register while the next beat
// is accepted. tap_count must be written only while idle; the block does not enforce it.
module fir_convolution_engine #(
	parameter int MAX_TAPS = fce_pkg::MAX_TAPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	fce_in_if.sink                           item,
	fce_out_if.source                        result,
	input  logic                             cfg_we,
	input  logic [fce_pkg::TAP_COUNT_W-1:0]  cfg_wdata
);

	localparam int CW   = $clog2(MAX_TAPS);
	localparam int CMPW = (CW + 1 > fce_pkg::TAP_COUNT_W) ? CW + 1 : fce_pkg::TAP_COUNT_W;
	localparam logic [CW-1:0] LAST_STEP = CW'(MAX_TAPS - 1);

	fce_pkg::fce_state_t               state_q, state_d;
	logic [CW-1:0]                     step_q;
	logic [fce_pkg::TAP_COUNT_W-1:0]   tap_count_q;
	logic                              out_valid_q;
	logic signed [fce_pkg::ACC_W-1:0]  filtered_q;

	logic                              item_acc, push_acc, load_acc;
	logic                              out_load;
	fce_pkg::cell_ctl_t                cell_ctl;
	fce_pkg::mac_ctl_t                 mac_ctl;
	logic signed [fce_pkg::ACC_W-1:0]  total;

	logic signed [fce_pkg::SAMPLE_W-1:0] samp [MAX_TAPS];
	logic signed [fce_pkg::SAMPLE_W-1:0] taps [MAX_TAPS];

	assign item_acc = item.valid && item.ready;
	assign push_acc = item_acc && (item.cmd == fce_pkg::CMD_PUSH);
	assign load_acc = item_acc && (item.cmd == fce_pkg::CMD_LOAD);

	// Tap count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fce_pkg::TAP_COUNT_RST;
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	// Sequencer state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fce_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (push_acc) begin
				step_q <= '0;
			end else if (state_q == fce_pkg::ST_RUN && step_q != LAST_STEP) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Next state and control
	always_comb begin
		state_d         = state_q;
		item.ready      = 1'b0;
		out_load        = 1'b0;
		cell_ctl.push   = 1'b0;
		cell_ctl.rotate = 1'b0;
		mac_ctl.clear   = 1'b0;
		mac_ctl.step    = 1'b0;
		mac_ctl.active  = (CMPW'(step_q) < CMPW'(tap_count_q));
		unique case (state_q)
			fce_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (push_acc) begin
					cell_ctl.push = 1'b1;
					mac_ctl.clear = 1'b1;
					state_d       = fce_pkg::ST_RUN;
				end
			end
			fce_pkg::ST_RUN: begin
				cell_ctl.rotate = 1'b1;
				mac_ctl.step    = 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = fce_pkg::ST_FIN;
				end
			end
			fce_pkg::ST_FIN: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = fce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fce_pkg::ST_IDLE;
			end
		endcase
	end

	// Ring of cells: cell k holds x[n-k] and tap k when at rest
	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		localparam int NXT = (k == MAX_TAPS - 1) ? 0 : k + 1;
		logic                                tap_we;
		logic signed [fce_pkg::SAMPLE_W-1:0] prev;

		if (k < (1 << fce_pkg::TAP_INDEX_W)) begin : g_we
			assign tap_we = load_acc && (item.tap_index == fce_pkg::TAP_INDEX_W'(k));
		end else begin : g_no_we
			assign tap_we = 1'b0;
		end

		if (k == 0) begin : g_head
			assign prev = item.sample_value;
		end else begin : g_body
			assign prev = samp[k-1];
		end

		fce_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (cell_ctl),
			.tap_we      (tap_we),
			.tap_wdata   (item.sample_value),
			.sample_prev (prev),
			.sample_next (samp[NXT]),
			.tap_next    (taps[NXT]),
			.sample_q    (samp[k]),
			.tap_q       (taps[k])
		);
	end

	// Shared multiply-accumulate fed from cell 0
	fce_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.sample (samp[0]),
		.tap    (taps[0]),
		.total  (total)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q <= total;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.filtered_value = filtered_q;

	// A new result is only raised from the finish state
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == fce_pkg::ST_FIN))
		else $error("result raised outside of pass completion");

	// A push beat starts a pass at step zero
	a_push_starts_pass: assert property (@(posedge clk) disable iff (!arst_n)
		push_acc |=> (state_q == fce_pkg::ST_RUN && step_q == '0))
		else $error("push beat did not start a pass");

	// The pass walks every cell exactly once
	a_step_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fce_pkg::ST_RUN && step_q != LAST_STEP)
		|=> (state_q == fce_pkg::ST_RUN && step_q == $past(step_q) + 1'b1))
		else $error("step counter skipped");

	a_pass_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fce_pkg::ST_RUN && step_q == LAST_STEP) |=> state_q == fce_pkg::ST_FIN)
		else $error("pass did not end after last cell");

endmodule
